FILE: src/eiec_pkg.sv
// Shared types, codes and constants for the edge interrupt event controller.
package eiec_pkg;

  localparam int BANK_WIDTH = 32;
  localparam int NUM_LINES_DEF = 40;
  localparam int BANK1_LINES_DEF = 8;

  localparam logic [31:0] DIRECT_MASK0 = 32'hff820000;
  localparam logic [31:0] DIRECT_MASK1 = 32'h00000087;

  // Register indexes within a bank.
  localparam logic [2:0] REG_IMR  = 3'd0;
  localparam logic [2:0] REG_EMR  = 3'd1;
  localparam logic [2:0] REG_RTSR = 3'd2;
  localparam logic [2:0] REG_FTSR = 3'd3;
  localparam logic [2:0] REG_SWIER = 3'd4;
  localparam logic [2:0] REG_PR   = 3'd5;
  localparam logic [7:0] BANK1_BASE = 8'd8;

  // Input func codes.
  localparam logic [1:0] FUNC_READ  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_LINE  = 2'd2;

  // Output event kinds.
  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_PULSE = 2'd1;
  localparam logic [1:0] EV_LEVEL = 2'd2;

  // Decoded command ops.
  localparam logic [2:0] OP_NOP   = 3'd0;
  localparam logic [2:0] OP_READ  = 3'd1;
  localparam logic [2:0] OP_WRITE = 3'd2;
  localparam logic [2:0] OP_LINE  = 3'd3;
  localparam logic [2:0] OP_BAD   = 3'd4;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  word_offset;
    logic [31:0] write_data;
    logic [5:0]  line_number;
    logic        line_level;
  } in_word_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [1:0]  event_kind;
    logic [5:0]  event_line;
    logic        event_level;
    logic        bad_offset;
    logic        last;
  } out_word_t;

  typedef struct packed {
    logic [2:0]  op;
    logic        bank;
    logic [2:0]  regi;
    logic [31:0] data;
    logic [4:0]  bit_idx;
    logic        level;
  } cmd_t;

  typedef struct packed {
    logic              full;
    logic              not_empty;
    logic [QCNT_W-1:0] count;
  } q_status_t;

  typedef struct packed {
    logic scanning;
    logic pop;
  } back_status_t;

endpackage

FILE: src/eiec_front.sv
// Front end: decodes an input word into a command for the back end.
module eiec_front import eiec_pkg::*; #(
  parameter int NUM_LINES = NUM_LINES_DEF,
  parameter int BANK1_LINES = BANK1_LINES_DEF
) (
  input  in_word_t in_word,
  output cmd_t     cmd
);

  logic       bank;
  logic [7:0] rel;
  logic       ok;
  logic       line_ok;

  always_comb begin
    bank = (in_word.word_offset >= BANK1_BASE);
    rel = in_word.word_offset - (bank ? BANK1_BASE : 8'd0);
    ok = (rel <= {5'd0, REG_PR});
    line_ok = ({1'b0, in_word.line_number} < 7'(NUM_LINES)) &&
              (!in_word.line_number[5] ||
               ({1'b0, in_word.line_number[4:0]} < 6'(BANK1_LINES)));

    cmd.op = OP_NOP;
    cmd.bank = bank;
    cmd.regi = rel[2:0];
    cmd.data = in_word.write_data;
    cmd.bit_idx = in_word.line_number[4:0];
    cmd.level = in_word.line_level;
    case (in_word.func)
      FUNC_READ: begin
        cmd.op = ok ? OP_READ : OP_BAD;
      end
      FUNC_WRITE: begin
        cmd.op = ok ? OP_WRITE : OP_BAD;
      end
      FUNC_LINE: begin
        cmd.bank = in_word.line_number[5];
        cmd.op = line_ok ? OP_LINE : OP_NOP;
      end
      default: begin
        cmd.op = OP_NOP;
      end
    endcase
  end

endmodule

FILE: src/eiec_queue.sv
// Two-entry command queue between the front and back ends.
module eiec_queue import eiec_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  cmd_t      push_cmd,
  input  logic      pop,
  output cmd_t      head_cmd,
  output q_status_t status
);

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10: count_r <= count_r + 1'b1;
        2'b01: count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  assign head_cmd = mem_r[rd_ptr_r];
  assign status.full = (count_r == QCNT_W'(QDEPTH));
  assign status.not_empty = (count_r != '0);
  assign status.count = count_r;

endmodule

FILE: src/eiec_back.sv
// Back end: register banks, command execution, pulse scan and output register.
module eiec_back import eiec_pkg::*; #(
  parameter int BANK1_LINES = BANK1_LINES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cmd_valid,
  input  cmd_t         cmd,
  output back_status_t status,
  output logic         out_valid,
  input  logic         out_stall,
  output out_word_t    out_word
);

  localparam logic [31:0] VALID1 = 32'((64'd1 << BANK1_LINES) - 64'd1);

  logic [31:0] imr_r [2], imr_nxt [2];
  logic [31:0] emr_r [2], emr_nxt [2];
  logic [31:0] rtsr_r [2], rtsr_nxt [2];
  logic [31:0] ftsr_r [2], ftsr_nxt [2];
  logic [31:0] swier_r [2], swier_nxt [2];
  logic [31:0] pr_r [2], pr_nxt [2];
  logic [31:0] lvl_r [2], lvl_nxt [2];

  logic [31:0] scan_r, scan_nxt;
  logic        scan_bank_r, scan_bank_nxt;
  logic        scanning_r, scanning_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_word_t   out_word_r, out_word_nxt;

  logic        adv, pop;
  logic [31:0] vmask, cmask, dmask, bitm, setv, pend, clr, scan_rest;
  logic [4:0]  low_idx;
  logic        b;

  always_comb begin
    low_idx = '0;
    for (int i = 31; i >= 0; i--) begin
      if (scan_r[i]) low_idx = 5'(i);
    end
  end

  always_comb begin
    imr_nxt = imr_r;
    emr_nxt = emr_r;
    rtsr_nxt = rtsr_r;
    ftsr_nxt = ftsr_r;
    swier_nxt = swier_r;
    pr_nxt = pr_r;
    lvl_nxt = lvl_r;
    scan_nxt = scan_r;
    scan_bank_nxt = scan_bank_r;
    scanning_nxt = scanning_r;
    out_word_nxt = out_word_r;
    out_valid_nxt = out_valid_r && out_stall;

    b = cmd.bank;
    vmask = b ? VALID1 : 32'hffffffff;
    dmask = b ? DIRECT_MASK1 : DIRECT_MASK0;
    cmask = vmask & ~dmask;
    bitm = 32'd1 << cmd.bit_idx;
    setv = cmd.data & cmask;
    pend = setv & ~swier_r[b] & imr_r[b] & ~pr_r[b];
    clr = pr_r[b] & cmd.data & cmask;
    scan_rest = scan_r & (scan_r - 32'd1);

    adv = !out_valid_r || !out_stall;
    pop = adv && !scanning_r && cmd_valid;

    if (adv && scanning_r) begin
      // one pulse per newly pending line, lowest line first
      out_valid_nxt = 1'b1;
      out_word_nxt = '0;
      out_word_nxt.event_kind = EV_PULSE;
      out_word_nxt.event_line = {scan_bank_r, low_idx};
      out_word_nxt.last = (scan_rest == '0);
      scan_nxt = scan_rest;
      scanning_nxt = (scan_rest != '0);
    end else if (pop) begin
      out_valid_nxt = 1'b1;
      out_word_nxt = '0;
      out_word_nxt.last = 1'b1;
      case (cmd.op)
        OP_BAD: begin
          out_word_nxt.bad_offset = 1'b1;
        end
        OP_READ: begin
          case (cmd.regi)
            REG_IMR:  out_word_nxt.read_data = imr_r[b];
            REG_EMR:  out_word_nxt.read_data = emr_r[b];
            REG_RTSR: out_word_nxt.read_data = rtsr_r[b];
            REG_FTSR: out_word_nxt.read_data = ftsr_r[b];
            REG_SWIER: out_word_nxt.read_data = swier_r[b];
            default:  out_word_nxt.read_data = pr_r[b];
          endcase
        end
        OP_WRITE: begin
          case (cmd.regi)
            REG_IMR:  imr_nxt[b] = cmd.data & vmask;
            REG_EMR:  emr_nxt[b] = cmd.data & vmask;
            REG_RTSR: rtsr_nxt[b] = setv;
            REG_FTSR: ftsr_nxt[b] = setv;
            REG_SWIER: begin
              swier_nxt[b] = setv;
              pr_nxt[b] = pr_r[b] | pend;
              if (pend != '0) begin
                // no word now; the scan state is registered and then emits the pulses
                out_valid_nxt = out_valid_r && out_stall;
                out_word_nxt = out_word_r;
                scan_nxt = pend;
                scan_bank_nxt = b;
                scanning_nxt = 1'b1;
              end
            end
            default: begin
              pr_nxt[b] = pr_r[b] & ~clr;
              swier_nxt[b] = swier_r[b] & ~clr;
            end
          endcase
        end
        OP_LINE: begin
          if (((lvl_r[b] & bitm) != '0) != cmd.level) begin
            lvl_nxt[b] = cmd.level ? (lvl_r[b] | bitm) : (lvl_r[b] & ~bitm);
            if ((imr_r[b] & bitm) != '0) begin
              if ((dmask & bitm) != '0) begin
                out_word_nxt.event_kind = EV_LEVEL;
                out_word_nxt.event_line = {b, cmd.bit_idx};
                out_word_nxt.event_level = cmd.level;
              end else if (( cmd.level && ((rtsr_r[b] & bitm) != '0)) ||
                           (!cmd.level && ((ftsr_r[b] & bitm) != '0))) begin
                pr_nxt[b] = pr_r[b] | bitm;
                out_word_nxt.event_kind = EV_PULSE;
                out_word_nxt.event_line = {b, cmd.bit_idx};
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      imr_r[0] <= DIRECT_MASK0;
      imr_r[1] <= DIRECT_MASK1;
      for (int i = 0; i < 2; i++) begin
        emr_r[i] <= '0;
        rtsr_r[i] <= '0;
        ftsr_r[i] <= '0;
        swier_r[i] <= '0;
        pr_r[i] <= '0;
        lvl_r[i] <= '0;
      end
      scanning_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      imr_r <= imr_nxt;
      emr_r <= emr_nxt;
      rtsr_r <= rtsr_nxt;
      ftsr_r <= ftsr_nxt;
      swier_r <= swier_nxt;
      pr_r <= pr_nxt;
      lvl_r <= lvl_nxt;
      scanning_r <= scanning_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_r <= scan_nxt;
    scan_bank_r <= scan_bank_nxt;
    out_word_r <= out_word_nxt;
  end

  assign status.scanning = scanning_r;
  assign status.pop = pop;
  assign out_valid = out_valid_r;
  assign out_word = out_word_r;

endmodule

FILE: src/edge_interrupt_event_controller_core.sv
// Top level of the edge interrupt event controller: front, queue, back.
//
// Input channel (in_valid / in_stall / in_word) carries bus reads, bus
// writes and line level changes. A word is taken at a clock edge with
// in_valid high and in_stall low; in_stall rises only while the two-entry
// command queue is full.
// Result channel (out_valid / out_stall / out_word) is fed by an output
// register. The back end pops one command per cycle while that register
// is free or being drained and no pulse scan is running.
// A read, write or line change is written into the queue when accepted,
// then popped into the output register that drives out_word. Such items
// go through at one per cycle while the output register can advance and
// no pulse scan runs. A software trigger write that pends lines first
// updates the bank, then gives one pulse word per line, lowest line first,
// set by the lowest-set-bit scan over the pending word; last marks the end.
// While out_stall and out_valid are high, the output register holds and
// the back end waits; the front keeps taking words until the queue fills.
// Reset (rst_n low, synchronous) loads the mask reset values, clears all
// other bank registers, empties the queue and drops out_valid.
module edge_interrupt_event_controller_core import eiec_pkg::*; #(
  parameter int NUM_LINES = NUM_LINES_DEF,
  parameter int BANK1_LINES = BANK1_LINES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  cmd_t         dec_cmd, head_cmd;
  q_status_t    q_stat;
  back_status_t b_stat;
  logic         push;

  assign in_stall = q_stat.full;
  assign push = in_valid && !q_stat.full;

  eiec_front #(
    .NUM_LINES  (NUM_LINES),
    .BANK1_LINES(BANK1_LINES)
  ) u_front (
    .in_word(in_word),
    .cmd    (dec_cmd)
  );

  eiec_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_cmd(dec_cmd),
    .pop     (b_stat.pop),
    .head_cmd(head_cmd),
    .status  (q_stat)
  );

  eiec_back #(
    .BANK1_LINES(BANK1_LINES)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_valid(q_stat.not_empty),
    .cmd      (head_cmd),
    .status   (b_stat),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count <= QCNT_W'(QDEPTH))
    else $error("queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    b_stat.pop |-> q_stat.not_empty && !b_stat.scanning)
    else $error("pop from empty queue or during scan");

  a_scan_out: assert property (@(posedge clk) disable iff (!rst_n)
    $past(b_stat.scanning) && b_stat.scanning |-> out_valid)
    else $error("scan running without output word");

  a_full_pop: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full && !b_stat.pop |=> q_stat.full)
    else $error("queue drained without pop");

endmodule
